FILE: rtl/bimode_branch_predictor_defines.svh
// Assertion macros for the bi-mode branch predictor checker.
// No dependencies; included by the checker file only.
`ifndef BIMODE_BRANCH_PREDICTOR_DEFINES_SVH
`define BIMODE_BRANCH_PREDICTOR_DEFINES_SVH

// Antecedent this cycle implies consequent in the next cycle.
`define BMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bimode predictor: next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define BMP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bimode predictor: same-cycle check failed");

`endif

FILE: rtl/bmp_pkg.sv
// Shared types and constants for the bi-mode branch predictor.
// No dependencies; used by bmp_ctrl, bmp_datapath and the top level.
package bmp_pkg;

	// func field codes
	localparam logic FUNC_PREDICT = 1'b0;
	localparam logic FUNC_UPDATE  = 1'b1;

	// 2-bit saturating counter limits
	localparam logic [1:0] CTR_MIN = 2'd0;
	localparam logic [1:0] CTR_MAX = 2'd3;

	// controller -> datapath commands
	typedef struct packed {
		logic clear_we; // clearing pass: zero one entry of every table
		logic accept;   // transaction taken: capture fields, issue table reads
		logic exec;     // read data valid: resolve predict or write back update
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic clear_last; // clearing pass is at its final entry
		logic is_update;  // captured transaction is an update
	} sts_t;

	function automatic logic [1:0] sat_toward(input logic [1:0] ctr, input logic up);
		logic [1:0] res;
		res = ctr;
		if (up) begin
			if (ctr != CTR_MAX) res = ctr + 2'd1;
		end else begin
			if (ctr != CTR_MIN) res = ctr - 2'd1;
		end
		return res;
	endfunction

endpackage

FILE: rtl/bmp_ctrl.sv
// Controller FSM for the bi-mode branch predictor: clear pass, accept, execute.
// Depends on bmp_pkg (cmd_t, sts_t).
module bmp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  bmp_pkg::sts_t  sts,
	output bmp_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign cmd.clear_we = (state_q == ST_CLEAR);
	assign cmd.accept   = in_valid && in_ready;
	// a predict waits here while the previous result is still unclaimed
	assign cmd.exec     = (state_q == ST_EXEC) && (sts.is_update || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.exec) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase

			if (cmd.exec && !sts.is_update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/bmp_datapath.sv
// Datapath for the bi-mode branch predictor: three counter tables, history, latches.
// Depends on bmp_pkg (cmd_t, sts_t, func codes, sat_toward).
module bmp_datapath #(
	parameter int DIRECTION_INDEX_BITS = 12,
	parameter int CHOICE_INDEX_BITS    = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bmp_pkg::cmd_t  cmd,
	output bmp_pkg::sts_t  sts,
	input  logic           func,
	input  logic [31:0]    pc,
	input  logic           outcome,
	output logic           predict_taken
);

	localparam int DIR_DEPTH = 1 << DIRECTION_INDEX_BITS;
	localparam int CHO_DEPTH = 1 << CHOICE_INDEX_BITS;
	localparam int CLR_BITS  = (DIRECTION_INDEX_BITS > CHOICE_INDEX_BITS) ?
		DIRECTION_INDEX_BITS : CHOICE_INDEX_BITS;

	logic [1:0] taken_mem [DIR_DEPTH];
	logic [1:0] ntaken_mem [DIR_DEPTH];
	logic [1:0] choice_mem [CHO_DEPTH];

	logic [CLR_BITS-1:0]             clr_cnt_q;
	logic [DIRECTION_INDEX_BITS-1:0] hist_q;
	logic [DIRECTION_INDEX_BITS-1:0] latched_idx_q;
	logic                            taken_guess_q;
	logic                            ntaken_guess_q;
	logic                            predict_taken_q;

	logic                            func_s1;
	logic                            outcome_s1;
	logic [CHOICE_INDEX_BITS-1:0]    cidx_s1;
	logic [DIRECTION_INDEX_BITS-1:0] idx_s1;
	logic [1:0]                      taken_rd_s1;
	logic [1:0]                      ntaken_rd_s1;
	logic [1:0]                      choice_rd_s1;

	logic [DIRECTION_INDEX_BITS-1:0] pred_idx;
	logic [DIRECTION_INDEX_BITS-1:0] dir_raddr;
	logic                            do_update;
	logic [1:0]                      choice_next;

	logic                            t_we, n_we, c_we;
	logic [DIRECTION_INDEX_BITS-1:0] dir_waddr;
	logic [CHOICE_INDEX_BITS-1:0]    c_waddr;
	logic [1:0]                      t_wdata, n_wdata, c_wdata;

	assign pred_idx  = hist_q ^ pc[DIRECTION_INDEX_BITS-1:0];
	assign dir_raddr = (func == bmp_pkg::FUNC_PREDICT) ? pred_idx : latched_idx_q;
	assign do_update = cmd.exec && (func_s1 == bmp_pkg::FUNC_UPDATE);

	assign sts.clear_last = &clr_cnt_q;
	assign sts.is_update  = (func_s1 == bmp_pkg::FUNC_UPDATE);
	assign predict_taken  = predict_taken_q;

	always_comb begin
		choice_next = choice_rd_s1;
		if (taken_guess_q && outcome_s1 && choice_rd_s1 != bmp_pkg::CTR_MAX) begin
			choice_next = choice_rd_s1 + 2'd1;
		end else if (!ntaken_guess_q && !outcome_s1 && choice_rd_s1 != bmp_pkg::CTR_MIN) begin
			choice_next = choice_rd_s1 - 2'd1;
		end
	end

	// write ports: clearing pass or update write-back
	always_comb begin
		t_we      = cmd.clear_we || (do_update && choice_rd_s1[1]);
		n_we      = cmd.clear_we || (do_update && !choice_rd_s1[1]);
		c_we      = cmd.clear_we || do_update;
		dir_waddr = cmd.clear_we ? clr_cnt_q[DIRECTION_INDEX_BITS-1:0] : latched_idx_q;
		c_waddr   = cmd.clear_we ? clr_cnt_q[CHOICE_INDEX_BITS-1:0] : cidx_s1;
		t_wdata   = cmd.clear_we ? 2'd0 : bmp_pkg::sat_toward(taken_rd_s1, outcome_s1);
		n_wdata   = cmd.clear_we ? 2'd0 : bmp_pkg::sat_toward(ntaken_rd_s1, outcome_s1);
		c_wdata   = cmd.clear_we ? 2'd0 : choice_next;
	end

	always_ff @(posedge clk) begin
		if (t_we) taken_mem[dir_waddr] <= t_wdata;
		if (cmd.accept) taken_rd_s1 <= taken_mem[dir_raddr];
	end

	always_ff @(posedge clk) begin
		if (n_we) ntaken_mem[dir_waddr] <= n_wdata;
		if (cmd.accept) ntaken_rd_s1 <= ntaken_mem[dir_raddr];
	end

	always_ff @(posedge clk) begin
		if (c_we) choice_mem[c_waddr] <= c_wdata;
		if (cmd.accept) choice_rd_s1 <= choice_mem[pc[CHOICE_INDEX_BITS-1:0]];
	end

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_s1    <= func;
			outcome_s1 <= outcome;
			cidx_s1    <= pc[CHOICE_INDEX_BITS-1:0];
			idx_s1     <= pred_idx;
		end
		if (cmd.exec && !do_update) begin
			predict_taken_q <= choice_rd_s1[1] ? taken_rd_s1[1] : ntaken_rd_s1[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q      <= '0;
			hist_q         <= '0;
			latched_idx_q  <= '0;
			taken_guess_q  <= 1'b0;
			ntaken_guess_q <= 1'b0;
		end else begin
			if (cmd.clear_we) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.exec) begin
				if (do_update) begin
					hist_q <= {hist_q[DIRECTION_INDEX_BITS-2:0], outcome_s1};
				end else begin
					latched_idx_q  <= idx_s1;
					taken_guess_q  <= taken_rd_s1[1];
					ntaken_guess_q <= ntaken_rd_s1[1];
				end
			end
		end
	end

endmodule

FILE: rtl/bimode_branch_predictor.sv
// Bi-mode branch predictor, top level. Every transaction is accepted, then
// executed: the accept edge issues the table reads, the execute edge resolves a
// predict or writes back an update (one read-modify-write on single-port tables).
// A predict waits in execute while the previous result is unclaimed, and no new
// transaction is accepted until the current one has executed. After reset a
// clearing pass zeroes the tables, with in_ready low throughout.
module bimode_branch_predictor #(
	parameter int DIRECTION_INDEX_BITS = 12,
	parameter int CHOICE_INDEX_BITS    = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] pc,
	input  logic        outcome,
	// result channel (predict transactions only)
	output logic        out_valid,
	input  logic        out_ready,
	output logic        predict_taken
);

	// command/status bundle between controller and datapath
	bmp_pkg::cmd_t cmd;
	bmp_pkg::sts_t sts;

	// Controller: clear pass, then IDLE <-> EXEC per transaction. It also owns
	// the result valid flag, so a finished predict can sit in the output register
	// while the next transaction is accepted; only a second predict waits for it.
	bmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: taken-biased, not-taken-biased and choice tables, global
	// history and the latched index/guesses from the last predict.
	bmp_datapath #(
		.DIRECTION_INDEX_BITS (DIRECTION_INDEX_BITS),
		.CHOICE_INDEX_BITS    (CHOICE_INDEX_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.pc            (pc),
		.outcome       (outcome),
		.predict_taken (predict_taken)
	);

endmodule

FILE: rtl/bmp_checker.sv
// Port-level assertion checker for the bi-mode branch predictor, bound to the top.
// Depends on bimode_branch_predictor_defines.svh and bmp_pkg (func codes).
`include "bimode_branch_predictor_defines.svh"

module bmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        func,
	input logic        out_valid,
	input logic        out_ready,
	input logic        predict_taken
);

	// a held result keeps its value
	`BMP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(predict_taken))
	// never accept on consecutive edges
	`BMP_ASSERT_NEXT(a_no_b2b_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// a fresh result comes from a predict accepted earlier, with no stall in between
	`BMP_ASSERT_NOW(a_result_source, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready && (func == bmp_pkg::FUNC_PREDICT), 2))

endmodule

bind bimode_branch_predictor bmp_checker u_bmp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.func          (func),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.predict_taken (predict_taken)
);

FILE: dv/bimode_branch_predictor_test.sv
// Self-checking testbench for bimode_branch_predictor: directed and random
// predict/update traffic under several idle and stall mixes.
// Depends on rtl/bmp_pkg.sv and rtl/bimode_branch_predictor.sv.
`timescale 1ns / 1ps

module bimode_branch_predictor_test;

	localparam int DIR_BITS = 12;
	localparam int CHO_BITS = 12;
	localparam int RANDOM_ITEMS = 850;
	localparam int REPORT_LIMIT = 10;

	// Own copy of the predictor state. Every accepted transaction goes through
	// note_branch; predicts leave the direction they must produce in
	// pending_dirs, and check_direction compares each delivered result against
	// the oldest one.
	class direction_model;
		logic [1:0]          taken_bank[1 << DIR_BITS];
		logic [1:0]          not_taken_bank[1 << DIR_BITS];
		logic [1:0]          choice_tbl[1 << CHO_BITS];
		logic [DIR_BITS-1:0] ghist;
		logic [DIR_BITS-1:0] lat_t_idx;
		logic [DIR_BITS-1:0] lat_nt_idx;
		logic                lat_t_guess;
		logic                lat_nt_guess;
		logic                pending_dirs[$];
		int                  mismatches;

		function new();
			foreach (taken_bank[i]) taken_bank[i] = bmp_pkg::CTR_MIN;
			foreach (not_taken_bank[i]) not_taken_bank[i] = bmp_pkg::CTR_MIN;
			foreach (choice_tbl[i]) choice_tbl[i] = bmp_pkg::CTR_MIN;
			ghist = '0;
			lat_t_idx = '0;
			lat_nt_idx = '0;
			lat_t_guess = 1'b0;
			lat_nt_guess = 1'b0;
			mismatches = 0;
		endfunction

		function logic [1:0] nudge_counter(logic [1:0] ctr, logic up);
			if (up)
				return (ctr == bmp_pkg::CTR_MAX) ? ctr : ctr + 2'd1;
			return (ctr == bmp_pkg::CTR_MIN) ? ctr : ctr - 2'd1;
		endfunction

		function void note_branch(logic f, logic [31:0] p, logic o);
			logic [CHO_BITS-1:0] ci;
			logic [1:0]          choose;
			logic [DIR_BITS-1:0] idx;
			ci = p[CHO_BITS-1:0];
			choose = choice_tbl[ci];
			if (f == bmp_pkg::FUNC_PREDICT) begin
				idx = ghist ^ p[DIR_BITS-1:0];
				lat_t_idx = idx;
				lat_nt_idx = idx;
				lat_t_guess = taken_bank[idx][1];
				lat_nt_guess = not_taken_bank[idx][1];
				pending_dirs.push_back(choose[1] ? lat_t_guess : lat_nt_guess);
				return;
			end
			// choice trains on the update pc, banks on the latched index
			if (lat_t_guess && o && choose != bmp_pkg::CTR_MAX)
				choice_tbl[ci] = choose + 2'd1;
			if (!lat_nt_guess && !o && choose != bmp_pkg::CTR_MIN)
				choice_tbl[ci] = choose - 2'd1;
			if (choose[1])
				taken_bank[lat_t_idx] = nudge_counter(taken_bank[lat_t_idx], o);
			else
				not_taken_bank[lat_nt_idx] = nudge_counter(not_taken_bank[lat_nt_idx], o);
			ghist = {ghist[DIR_BITS-2:0], o};
		endfunction

		function void report_miss(string what);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: mismatch: %s", $time, what);
		endfunction

		function void check_direction(logic got);
			logic want;
			if (pending_dirs.size() == 0) begin
				report_miss($sformatf("result %b with no predict outstanding", got));
				return;
			end
			want = pending_dirs.pop_front();
			if (got !== want)
				report_miss($sformatf("predict_taken expected %b actual %b", want, got));
		endfunction

		function int pending();
			return pending_dirs.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = bmp_pkg::FUNC_PREDICT;
	logic [31:0] pc = '0;
	logic        outcome = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        predict_taken;

	// idle mix of the current phase, in percent
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	direction_model dirs = new();

	bimode_branch_predictor #(
		.DIRECTION_INDEX_BITS(DIR_BITS),
		.CHOICE_INDEX_BITS(CHO_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.pc(pc),
		.outcome(outcome),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.predict_taken(predict_taken)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: sample at the edge (pre-edge values), then pick out_ready
	// for the next cycle from the phase's stall rate.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			dirs.check_direction(predict_taken);
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Drive one transaction. Entered in the active region of a rising edge and
	// left in the active region of the edge that accepted it, so the caller can
	// put the next item on the bus without dropping valid in between.
	task automatic push_branch(input logic f, input logic [31:0] p, input logic o);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pc <= p;
		outcome <= o;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		dirs.note_branch(f, p, o);
	endtask

	task automatic predict_then_update(input logic [31:0] p, input logic o);
		push_branch(bmp_pkg::FUNC_PREDICT, p, 1'b0);
		push_branch(bmp_pkg::FUNC_UPDATE, p, o);
	endtask

	// Random traffic. Most of it is predict/update pairs on a small set of
	// branch sites, each site with its own taken bias, so counters actually
	// walk toward saturation and history patterns repeat. High pc bits are
	// random so every address bit toggles. The rest is unpaired noise.
	task automatic random_traffic(input int n_items);
		logic [DIR_BITS-1:0] site_lo[8];
		int                  site_bias[8];
		int                  issued;
		int                  s;
		logic [31:0]         hi;
		logic [31:0]         p;
		issued = 0;
		foreach (site_lo[i]) begin
			site_lo[i] = DIR_BITS'($urandom);
			site_bias[i] = (i % 4 == 0) ? 5 : (i % 4 == 1) ? 30 : (i % 4 == 2) ? 70 : 95;
		end
		while (issued < n_items) begin
			if ($urandom_range(99) < 80) begin
				s = $urandom_range(7);
				hi = $urandom;
				p = {hi[31-DIR_BITS:0], site_lo[s]};
				if ($urandom_range(9) == 0) begin
					// update arrives with a different pc than the predict
					push_branch(bmp_pkg::FUNC_PREDICT, p, 1'b0);
					push_branch(bmp_pkg::FUNC_UPDATE, $urandom,
						$urandom_range(99) < site_bias[s]);
				end else begin
					predict_then_update(p, $urandom_range(99) < site_bias[s]);
				end
				issued += 2;
			end else begin
				push_branch(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
				issued++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. An update before any predict uses the
		// reset latches; extreme pcs next.
		push_branch(bmp_pkg::FUNC_UPDATE, 32'h0000_0000, 1'b1);
		push_branch(bmp_pkg::FUNC_PREDICT, 32'h0000_0000, 1'b0);
		push_branch(bmp_pkg::FUNC_PREDICT, 32'hFFFF_FFFF, 1'b0);
		push_branch(bmp_pkg::FUNC_UPDATE, 32'hFFFF_FFFF, 1'b0);
		// repeated taken outcomes shift ones into the history and step bank counters up
		repeat (5) predict_then_update(32'h8000_0A5A, 1'b1);
		// update pc different from predict pc
		push_branch(bmp_pkg::FUNC_PREDICT, 32'h0000_0123, 1'b0);
		push_branch(bmp_pkg::FUNC_UPDATE, 32'h7FFF_F456, 1'b0);
		// not-taken run shifts zeros into the history and nudges counters toward the bottom
		repeat (4) predict_then_update(32'h5555_0A5A, 1'b0);

		// Random part across the idle mixes.
		random_traffic(RANDOM_ITEMS / 4);
		send_idle_pct = 49;
		random_traffic(RANDOM_ITEMS / 4);
		send_idle_pct = 0;
		recv_stall_pct = 49;
		random_traffic(RANDOM_ITEMS / 4);
		send_idle_pct = 9;
		recv_stall_pct = 9;
		random_traffic(RANDOM_ITEMS / 4);
		in_valid <= 1'b0;

		// drain outstanding predicts, then let the pipeline settle
		while (dirs.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (dirs.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop: clearing pass plus the traffic stays well under this.
	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
